>>> design/gsp_pkg.sv
package gsp_pkg;

  localparam int MAX_SLOTS_DEFAULT = 256;

  // The slot bitmap is held as rows of this many in-use marks.
  localparam int ROW_BITS = 8;

  localparam logic [8:0] INIT_COUNT_RESET = 9'd16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_STATS = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  // Register index as decoded from paddr[2].
  typedef enum logic {
    REG_INIT_COUNT    = 1'b0,
    REG_GROWTH_LINEAR = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FREE  = 4'b1000
  } state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] slot_index;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot_index_out;
    logic [8:0] capacity_out;
    logic [8:0] active_count;
  } result_t;

  // Outcome of searching one bitmap row.
  typedef struct packed {
    logic       hit;       // a free slot below the capacity lies in this row
    logic [2:0] pos;       // lowest such slot within the row
    logic       last_row;  // the capacity ends within this row
    logic       next_row;  // the capacity ends exactly at the end of this row
  } scan_t;

endpackage

>>> design/growable_slot_pool_allocator_unit.sv
// Slot pool allocator with a growable capacity. A command is taken when start is high and busy
// is low; its single result appears on result for one cycle with done high and cannot be held
// off, so the receiver must take it then. The in-use marks live in a bitmap memory of rows of
// eight slots, and one row is searched per cycle: allocate reads rows until a free slot is
// found (at most ceil(capacity/8) rows), free reads and rewrites the addressed row, stats
// answers from its counters, and clear zeroes the bitmap. After reset the same zeroing pass
// runs over all ceil(MAX_SLOTS/8) rows, 32 at the default size, and busy stays high until it
// ends; register writes are taken at any time.
module growable_slot_pool_allocator_unit import gsp_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int IW    = (SW > 8) ? SW : 8;
  localparam int CW    = IW + 1;
  localparam int GW    = CW + 1;
  localparam int CAP_W = $clog2(MAX_SLOTS + 1);
  localparam int RS    = $clog2(ROW_BITS);
  localparam int ROWS  = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAP_RESET_INT =
    (int'(INIT_COUNT_RESET) > MAX_SLOTS) ? MAX_SLOTS : int'(INIT_COUNT_RESET);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);

  state_t              state;
  logic [RW-1:0]       row;
  logic [RW-1:0]       sweep_ptr;
  logic                clear_rsp;
  logic                free_ok_q;
  logic [RS-1:0]       free_bit;
  logic [8:0]          init_count;
  logic                growth_linear;
  logic [CAP_W-1:0]    capacity;
  logic [CAP_W-1:0]    used_total;

  logic                we;
  logic [RW-1:0]       waddr;
  logic [ROW_BITS-1:0] wdata;
  logic [RW-1:0]       raddr;
  logic [ROW_BITS-1:0] rdata;
  scan_t               scan;

  logic [IW-1:0]       idx_w;
  logic [RW-1:0]       idx_row;
  logic                free_ok;
  logic [CW-1:0]       cap_cw;
  logic [GW-1:0]       eff_init;
  logic [GW-1:0]       grow_sum;
  logic [GW-1:0]       grown;
  logic                at_max;
  logic [RW+RS-1:0]    grant;
  logic                free_hit;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_INIT_COUNT:    prdata = 32'(init_count);
      REG_GROWTH_LINEAR: prdata = 32'(growth_linear);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    idx_w   = IW'(cmd.slot_index);
    idx_row = RW'(idx_w >> RS);
    free_ok = (CW'(idx_w) < CW'(MAX_SLOTS)) && (CW'(idx_w) < CW'(capacity));
    cap_cw  = CW'(capacity);
    if (init_count == '0) begin
      eff_init = GW'(1);
    end else if (GW'(init_count) > GW'(MAX_SLOTS)) begin
      eff_init = GW'(MAX_SLOTS);
    end else begin
      eff_init = GW'(init_count);
    end
    grow_sum = growth_linear ? GW'(capacity) + eff_init : GW'(capacity) << 1;
    grown    = (grow_sum > GW'(MAX_SLOTS)) ? GW'(MAX_SLOTS) : grow_sum;
    at_max   = cap_cw >= CW'(MAX_SLOTS);
    grant    = {row, scan.pos};
    free_hit = free_ok_q && rdata[free_bit];
  end

  // Read address for the row that the next cycle looks at.
  always_comb begin
    raddr = row + RW'(1);
    if (state == S_IDLE) begin
      raddr = (cmd.opcode == OP_FREE) ? idx_row : '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = row;
    wdata = rdata;
    case (state)
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_ptr;
        wdata = '0;
      end
      S_SCAN: begin
        if (scan.hit) begin
          we    = 1'b1;
          wdata = rdata | (ROW_BITS'(1) << scan.pos);
        end else if (scan.last_row && !at_max) begin
          // The first new slot sits at the old capacity; marks above it are all clear.
          we    = 1'b1;
          waddr = RW'(cap_cw >> RS);
          wdata = (scan.next_row ? '0 : rdata) | (ROW_BITS'(1) << cap_cw[RS-1:0]);
        end
      end
      S_FREE: begin
        if (free_hit) begin
          we    = 1'b1;
          wdata = rdata & ~(ROW_BITS'(1) << free_bit);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  gsp_bitmap #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gsp_scan #(
    .CW (CW),
    .RW (RW)
  ) u_scan (
    .row      (row),
    .row_data (rdata),
    .capacity (cap_cw),
    .scan     (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_ptr     <= '0;
      clear_rsp     <= 1'b0;
      init_count    <= INIT_COUNT_RESET;
      growth_linear <= 1'b0;
      capacity      <= CAP_RESET;
      used_total    <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_INIT_COUNT:    init_count    <= pwdata[8:0];
          REG_GROWTH_LINEAR: growth_linear <= pwdata[0];
          default: ;
        endcase
      end

      case (state)
        S_SWEEP: begin
          sweep_ptr <= sweep_ptr + RW'(1);
          if (sweep_ptr == RW'(ROWS - 1)) begin
            state     <= S_IDLE;
            sweep_ptr <= '0;
            if (clear_rsp) begin
              clear_rsp  <= 1'b0;
              capacity   <= CAP_W'(eff_init);
              used_total <= '0;
              done       <= 1'b1;
              result     <= '{ST_OK, 8'd0, 9'(eff_init), 9'd0};
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            case (cmd.opcode)
              OP_ALLOC: begin
                row   <= '0;
                state <= S_SCAN;
              end
              OP_FREE: begin
                row       <= idx_row;
                free_bit  <= cmd.slot_index[RS-1:0];
                free_ok_q <= free_ok;
                state     <= S_FREE;
              end
              OP_STATS: begin
                done   <= 1'b1;
                result <= '{ST_OK, 8'd0, 9'(capacity), 9'(used_total)};
              end
              OP_CLEAR: begin
                clear_rsp <= 1'b1;
                sweep_ptr <= '0;
                state     <= S_SWEEP;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan.hit) begin
            used_total <= used_total + CAP_W'(1);
            done       <= 1'b1;
            result     <= '{ST_OK, 8'(grant), 9'(capacity), 9'(used_total + CAP_W'(1))};
            state      <= S_IDLE;
          end else if (scan.last_row) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (at_max) begin
              result <= '{ST_FULL, 8'd0, 9'(capacity), 9'(used_total)};
            end else begin
              capacity   <= CAP_W'(grown);
              used_total <= used_total + CAP_W'(1);
              result     <= '{ST_OK, 8'(capacity), 9'(grown),
                              9'(used_total + CAP_W'(1))};
            end
          end else begin
            row <= row + RW'(1);
          end
        end
        S_FREE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (free_hit) begin
            used_total <= used_total - CAP_W'(1);
            result     <= '{ST_OK, 8'd0, 9'(capacity), 9'(used_total - CAP_W'(1))};
          end else begin
            result <= '{ST_NOT_USED, 8'd0, 9'(capacity), 9'(used_total)};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/gsp_bitmap.sv
module gsp_bitmap import gsp_pkg::*; #(
  parameter int ROWS = 32,
  parameter int RW   = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [RW-1:0]       waddr,
  input  logic [ROW_BITS-1:0] wdata,
  input  logic [RW-1:0]       raddr,
  output logic [ROW_BITS-1:0] rdata
);

  logic [ROW_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/gsp_scan.sv
module gsp_scan import gsp_pkg::*; #(
  parameter int CW = 10,
  parameter int RW = 5
) (
  input  logic [RW-1:0]       row,
  input  logic [ROW_BITS-1:0] row_data,
  input  logic [CW-1:0]       capacity,
  output scan_t               scan
);

  localparam int RS = $clog2(ROW_BITS);

  logic [CW-1:0]       base;
  logic [CW-1:0]       rem;
  logic [ROW_BITS-1:0] in_range;
  logic [ROW_BITS-1:0] free_bits;
  logic [2:0]          pos;

  always_comb begin
    base = CW'(row) << RS;
    rem  = capacity - base;
    // Slots at or above the capacity count as taken.
    if (rem >= CW'(ROW_BITS)) begin
      in_range = '1;
    end else begin
      in_range = ROW_BITS'({{ROW_BITS{1'b0}}, 1'b1} << rem[RS-1:0]) - ROW_BITS'(1);
    end
    free_bits = ~row_data & in_range;
    pos = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pos = 3'(b);
      end
    end
    scan.hit      = |free_bits;
    scan.pos      = pos;
    scan.last_row = rem <= CW'(ROW_BITS);
    scan.next_row = rem == CW'(ROW_BITS);
  end

endmodule

>>> design/gsp_checker.sv
module gsp_checker import gsp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    done,
  input result_t result
);

  // Stats is answered in the very next cycle.
  a_stats_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.opcode == OP_STATS |=> done && result.status == ST_OK)
    else $error("stats beat not answered in the next cycle");

  // Every other command needs at least one bitmap access before its result.
  a_other_later: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.opcode != OP_STATS |=> !done)
    else $error("result appeared too early for a bitmap command");

  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> result.active_count <= result.capacity_out)
    else $error("active count exceeds capacity");

  // A full pool has every slot in use and grants nothing.
  a_full_state: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |->
      result.active_count == result.capacity_out && result.slot_index_out == 8'd0)
    else $error("full status with a free slot or a granted slot");

endmodule

bind growable_slot_pool_allocator_unit gsp_checker u_gsp_checker (.*);
